[src/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants
// Field widths, item kinds and controller/datapath command types.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int DataW = 32;
	localparam int IdxW = 4;
	localparam int RadW = 31;
	localparam int PlaneSlots = 6;
	localparam int DefNumPlanes = 6;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_SPHERE = 2'd1,
		KIND_POINT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_RAW,
		OP_SQ,
		OP_SQRT,
		OP_DIV,
		OP_TEST_CLR,
		OP_TEST_MUL,
		OP_TEST_CMP
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] plane;
		logic [1:0] coef;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic reject;
	} stat_t;

endpackage

[src/vfc_if.sv]
// ----------------------------------------------------------------------------
// vfc_if: valid/ready channel
// Carries one input item or one result per transfer.
// ----------------------------------------------------------------------------
interface vfc_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [3:0] element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [30:0] sphere_radius;
	modport source (output valid, kind, element_index, element_value, pos_x, pos_y, pos_z,
		sphere_radius, input ready);
	modport sink (input valid, kind, element_index, element_value, pos_x, pos_y, pos_z,
		sphere_radius, output ready);
endinterface

interface vfc_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

[src/view_frustum_culling.sv]
// ----------------------------------------------------------------------------
// view_frustum_culling: frustum plane extraction and sphere/point culling
// Matrix loads, six-plane rebuild on element 15, inside tests.
// ----------------------------------------------------------------------------
// A test item steps through the planes one at a time (clear, multiply, compare,
// check) on the shared multiplier, stopping early on a reject, and then presents
// the result. A load of element 15 rebuilds all planes through the bit-serial
// square root and divider, and the input is held off meanwhile; other loads only
// write their matrix element and do not hold off the input.
module view_frustum_culling #(
	parameter int NumPlanes = vfc_pkg::DefNumPlanes
) (
	input  logic clk,
	input  logic arst_n,
	vfc_in_if.sink in_ch,
	vfc_out_if.source out_ch
);
	import vfc_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic cap, sphere_q;
	logic [3:0] idx_q;
	logic signed [31:0] val_q, x_q, y_q, z_q;
	logic [30:0] rad_q;

	always_ff @(posedge clk) begin
		if (cap) begin
			sphere_q <= kind_t'(in_ch.kind) == KIND_SPHERE;
			x_q <= in_ch.pos_x;
			y_q <= in_ch.pos_y;
			z_q <= in_ch.pos_z;
			rad_q <= in_ch.sphere_radius;
		end
	end
	assign idx_q = in_ch.element_index;
	assign val_q = in_ch.element_value;

	vfc_ctrl #(.NumPlanes(NumPlanes)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_kind(in_ch.kind), .in_idx(in_ch.element_index),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_inside(out_ch.inside_res),
		.cap, .cmd, .stat
	);

	vfc_datapath u_dp (
		.clk, .arst_n, .cmd,
		.ld_idx(idx_q), .ld_val(val_q),
		.px(x_q), .py(y_q), .pz(z_q), .rad(rad_q), .sphere(sphere_q),
		.stat
	);
endmodule

[src/vfc_datapath.sv]
// ----------------------------------------------------------------------------
// vfc_datapath: matrix/plane stores and arithmetic
// Shared multiplier, bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module vfc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  vfc_pkg::cmd_t cmd,
	input  logic [3:0] ld_idx,
	input  logic signed [31:0] ld_val,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic [30:0] rad,
	input  logic sphere,
	output vfc_pkg::stat_t stat
);
	import vfc_pkg::*;

	logic signed [31:0] mat_q [16];
	logic signed [31:0] pl_q [24];
	logic signed [31:0] raw_q [4];
	logic [64:0] sq_q;
	logic [31:0] t_q;
	logic [63:0] rem_q, bit_q, res_q;
	logic [5:0] cnt_q;
	logic div_busy_q, sqrt_busy_q;
	logic [48:0] dnum_q;
	logic [49:0] drem_q;
	logic [48:0] dquo_q;
	logic dneg_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] prod_s1;
	logic sqrt_done_q, div_done_q;

	logic [1:0] j;
	logic sub;
	logic signed [32:0] w, o, rs;
	logic signed [31:0] rsat;
	logic signed [31:0] ma, mb;
	logic [31:0] mag;

	assign j = cmd.plane[2:1];
	assign sub = ~cmd.plane[0];
	assign w = 33'(mat_q[{cmd.coef, 2'd3}]);
	assign o = 33'(mat_q[{cmd.coef, j}]);
	assign rs = sub ? w - o : w + o;
	assign rsat = (rs > 33'sd2147483647) ? 32'sh7fffffff :
		(rs < -33'sd2147483648) ? 32'sh80000000 : rs[31:0];
	assign mag = raw_q[cmd.coef][31] ? 32'(-raw_q[cmd.coef]) : raw_q[cmd.coef];

	always_comb begin
		ma = pl_q[{cmd.plane, cmd.coef}];
		unique case (cmd.coef)
			2'd0: mb = px;
			2'd1: mb = py;
			2'd2: mb = pz;
			default: mb = 32'sd65536;
		endcase
	end

	logic signed [66:0] thr;
	assign thr = sphere ? -$signed({36'd0, rad} <<< 16) : 67'sd0;
	assign stat.reject = sphere ? ($signed({acc_q[65], acc_q}) <= thr) : acc_q[65];
	assign stat.sqrt_done = sqrt_done_q;
	assign stat.div_done = div_done_q;

	logic [49:0] dtry;
	assign dtry = {drem_q[48:0], dnum_q[48]} - {18'd0, t_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
			for (int i = 0; i < 24; i++) pl_q[i] <= '0;
			sqrt_busy_q <= 1'b0;
			div_busy_q <= 1'b0;
			sqrt_done_q <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			sqrt_done_q <= 1'b0;
			div_done_q <= 1'b0;
			prod_s1 <= (cmd.op == OP_SQ) ? $signed({1'b0, 63'(mag * mag)}) : ma * mb;
			unique case (cmd.op)
				OP_LOAD: mat_q[ld_idx] <= ld_val;
				OP_RAW: begin
					raw_q[cmd.coef] <= rsat;
					sq_q <= '0;
				end
				OP_SQ: if (cmd.coef != 2'd0) sq_q <= sq_q + 65'(unsigned'(prod_s1));
				OP_SQRT: begin
					if (!sqrt_busy_q && !sqrt_done_q) begin
						sqrt_busy_q <= 1'b1;
						rem_q <= sq_q[63:0] + 64'(unsigned'(prod_s1));
						bit_q <= 64'h4000000000000000;
						res_q <= '0;
					end else if (!sqrt_busy_q) begin
					end else if (bit_q == 64'd0) begin
						sqrt_busy_q <= 1'b0;
						sqrt_done_q <= 1'b1;
						t_q <= res_q[31:0];
					end else begin
						if (rem_q >= res_q + bit_q) begin
							rem_q <= rem_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				OP_DIV: begin
					if (!div_busy_q && !div_done_q) begin
						div_busy_q <= 1'b1;
						dneg_q <= raw_q[cmd.coef][31];
						dnum_q <= {17'd0, mag} << 16;
						drem_q <= '0;
						dquo_q <= '0;
						cnt_q <= 6'd49;
					end else if (!div_busy_q) begin
					end else if (cnt_q == 6'd0) begin
						div_busy_q <= 1'b0;
						div_done_q <= 1'b1;
						if (t_q == 32'd0)
							pl_q[{cmd.plane, cmd.coef}] <= '0;
						else if (dneg_q)
							pl_q[{cmd.plane, cmd.coef}] <= (dquo_q > 49'd2147483648) ?
								32'sh80000000 : 32'(-dquo_q);
						else
							pl_q[{cmd.plane, cmd.coef}] <= (dquo_q > 49'd2147483647) ?
								32'sh7fffffff : dquo_q[31:0];
					end else begin
						cnt_q <= cnt_q - 6'd1;
						dnum_q <= dnum_q << 1;
						if (!dtry[49]) begin
							drem_q <= dtry;
							dquo_q <= {dquo_q[47:0], 1'b1};
						end else begin
							drem_q <= {drem_q[48:0], dnum_q[48]};
							dquo_q <= {dquo_q[47:0], 1'b0};
						end
					end
				end
				OP_TEST_CLR: acc_q <= '0;
				OP_TEST_MUL: if (cmd.coef != 2'd0) acc_q <= acc_q + 66'(prod_s1);
				OP_TEST_CMP: acc_q <= acc_q + 66'(prod_s1);
				default: ;
			endcase
		end
	end
endmodule

[src/vfc_ctrl.sv]
// ----------------------------------------------------------------------------
// vfc_ctrl: sequencer
// Steps the datapath through loads, plane rebuilds and plane tests.
// ----------------------------------------------------------------------------
module vfc_ctrl #(
	parameter int NumPlanes = vfc_pkg::DefNumPlanes
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] in_kind,
	input  logic [3:0] in_idx,
	output logic out_valid,
	input  logic out_ready,
	output logic out_inside,
	output logic cap,
	output vfc_pkg::cmd_t cmd,
	input  vfc_pkg::stat_t stat
);
	import vfc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RAW, S_SQ, S_SQRT, S_DIV, S_CLR, S_MUL, S_CMP, S_CHK, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] plane_q;
	logic [1:0] coef_q;
	logic inside_q;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = state_q == S_OUT;
	assign out_inside = inside_q;
	assign cap = in_valid && in_ready;

	always_comb begin
		cmd.plane = plane_q;
		cmd.coef = coef_q;
		unique case (state_q)
			S_RAW: cmd.op = OP_RAW;
			S_SQ: cmd.op = OP_SQ;
			S_SQRT: cmd.op = OP_SQRT;
			S_DIV: cmd.op = OP_DIV;
			S_CLR: cmd.op = OP_TEST_CLR;
			S_MUL: cmd.op = OP_TEST_MUL;
			S_CMP: cmd.op = OP_TEST_CMP;
			default: cmd.op = (cap && kind_t'(in_kind) == KIND_LOAD) ? OP_LOAD : OP_IDLE;
		endcase
		if (cmd.op == OP_LOAD) cmd.coef = in_idx[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plane_q <= '0;
			coef_q <= '0;
			inside_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (state_q == S_OUT && out_ready) state_q <= S_IDLE;
					if (cap) begin
						plane_q <= '0;
						coef_q <= '0;
						inside_q <= 1'b1;
						case (kind_t'(in_kind))
							KIND_LOAD: if (in_idx == 4'd15) state_q <= S_RAW;
							KIND_SPHERE, KIND_POINT: state_q <= S_CLR;
							default: ;
						endcase
					end
				end
				S_RAW: begin
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd3) state_q <= S_SQ;
				end
				S_SQ: begin
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd2) begin
						coef_q <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: if (stat.sqrt_done) state_q <= S_DIV;
				S_DIV: if (stat.div_done) begin
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd3) begin
						if (plane_q == 3'(PlaneSlots - 1)) state_q <= S_IDLE;
						else begin
							plane_q <= plane_q + 3'd1;
							state_q <= S_RAW;
						end
					end
				end
				S_CLR: state_q <= S_MUL;
				S_MUL: begin
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd3) state_q <= S_CMP;
				end
				S_CMP: state_q <= S_CHK;
				S_CHK: begin
					coef_q <= '0;
					if (stat.reject) begin
						inside_q <= 1'b0;
						state_q <= S_OUT;
					end else if (plane_q == 3'(NumPlanes - 1)) state_q <= S_OUT;
					else begin
						plane_q <= plane_q + 3'd1;
						state_q <= S_CLR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: view_frustum_culling testbench
// Drives matrix loads, sphere and point tests through the input channel,
// predicts each inside flag from a local copy of the matrix and planes, and
// checks results in order under random gaps and a long output stall.
// ----------------------------------------------------------------------------
module tb;
	import vfc_pkg::*;

	typedef struct {
		kind_t kind;
		logic [3:0] idx;
		logic signed [31:0] val;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0] rad;
	} item_t;

	class frustum_scoreboard;
		logic signed [31:0] mtx[16];
		logic signed [31:0] pln[24];
		bit inside_q[$];
		int errors;

		function new();
			foreach (mtx[i]) mtx[i] = '0;
			foreach (pln[i]) pln[i] = '0;
			errors = 0;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function bit [63:0] isqrt(bit [63:0] v);
			bit [63:0] res;
			bit [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void rebuild_planes();
			longint raw[4];
			longint w, o;
			bit [63:0] sq, m, t;
			int j;
			for (int p = 0; p < PlaneSlots; p++) begin
				j = p / 2;
				sq = 0;
				for (int k = 0; k < 4; k++) begin
					w = longint'(mtx[4*k+3]);
					o = longint'(mtx[4*k+j]);
					raw[k] = sat32((p % 2 == 0) ? w - o : w + o);
				end
				for (int k = 0; k < 3; k++) begin
					m = raw[k] < 0 ? -raw[k] : raw[k];
					sq += m * m;
				end
				t = isqrt(sq);
				for (int k = 0; k < 4; k++)
					pln[4*p+k] = (t != 0) ? 32'(sat32((raw[k] * 65536) / longint'(t))) : '0;
			end
		endfunction

		// accepted input: update state or queue the expected flag
		function void note(item_t it);
			logic signed [67:0] s;
			longint thr;
			bit in_frustum;
			case (it.kind)
				KIND_LOAD: begin
					mtx[it.idx] = it.val;
					if (it.idx == 4'd15) rebuild_planes();
				end
				KIND_SPHERE, KIND_POINT: begin
					in_frustum = 1;
					thr = -(longint'(it.rad) * 65536);
					for (int p = 0; p < DefNumPlanes; p++) begin
						s = 0;
						s += longint'(pln[4*p]) * longint'(it.x);
						s += longint'(pln[4*p+1]) * longint'(it.y);
						s += longint'(pln[4*p+2]) * longint'(it.z);
						s += longint'(pln[4*p+3]) * 65536;
						if (it.kind == KIND_SPHERE ? (s <= thr) : (s < 0)) begin
							in_frustum = 0;
							break;
						end
					end
					inside_q.push_back(in_frustum);
				end
				default: ;
			endcase
		endfunction

		function void check(bit got);
			bit want;
			if (inside_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0b", $time, got);
				errors++;
				return;
			end
			want = inside_q.pop_front();
			if (want !== got) begin
				$display("%0t: inside_res mismatch, expected %0b, got %0b", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	vfc_in_if in_ch();
	vfc_out_if out_ch();
	frustum_scoreboard sb;
	int cycles;
	int results_seen;
	bit no_idle;
	int sent;

	view_frustum_culling dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function int gap_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check(out_ch.inside_res);
			results_seen <= results_seen + 1;
		end

	// result side: random stalls, one long hold-off once traffic is flowing
	initial begin
		int g;
		bit held;
		held = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 20) begin
				held = 1;
				out_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	end

	task automatic send_item(item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= it.kind;
		in_ch.element_index <= it.idx;
		in_ch.element_value <= it.val;
		in_ch.pos_x <= it.x;
		in_ch.pos_y <= it.y;
		in_ch.pos_z <= it.z;
		in_ch.sphere_radius <= it.rad;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(it);
		sent++;
	endtask

	task automatic send_load(int idx, logic signed [31:0] v);
		item_t it;
		it = '{KIND_LOAD, 4'(idx), v, $urandom, $urandom, $urandom, 31'($urandom)};
		send_item(it);
	endtask

	task automatic send_test(kind_t k, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [30:0] r);
		item_t it;
		it = '{k, 4'($urandom), $urandom, x, y, z, r};
		send_item(it);
	endtask

	function logic signed [31:0] mat_value(int mode);
		case (mode)
			0: return $signed(32'($urandom_range(524288))) - 32'sd262144;
			1: return $urandom;
			default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	// whole matrix, element 15 last so the planes rebuild once
	task automatic load_matrix();
		logic signed [31:0] m[16];
		int mode, order[15];
		mode = $urandom_range(9) < 7 ? 0 : ($urandom_range(1) ? 1 : 2);
		foreach (m[i]) m[i] = mat_value($urandom_range(9) == 0 ? 2 : mode);
		if ($urandom_range(3) == 0) begin
			int j;
			j = $urandom_range(2);
			for (int k = 0; k < 3; k++) m[4*k+j] = m[4*k+3];
		end
		foreach (order[i]) order[i] = i;
		order.shuffle();
		foreach (order[i]) send_load(order[i], m[order[i]]);
		send_load(15, m[15]);
	endtask

	function logic signed [31:0] pos_value();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed(32'($urandom_range(1048576))) - 32'sd524288;
	endfunction

	function logic [30:0] rad_value();
		int r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return 31'($urandom);
		return 31'($urandom_range(131072));
	endfunction

	initial begin
		item_t it;
		sb = new();
		cycles = 0;
		results_seen = 0;
		sent = 0;
		no_idle = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_LOAD;
		in_ch.element_index <= '0;
		in_ch.element_value <= '0;
		in_ch.pos_x <= '0;
		in_ch.pos_y <= '0;
		in_ch.pos_z <= '0;
		in_ch.sphere_radius <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero planes: points pass, zero-radius spheres fail
		send_test(KIND_POINT, 32'sh80000000, 32'sh7fffffff, 0, 0);
		send_test(KIND_SPHERE, 0, 0, 0, 0);
		send_test(KIND_SPHERE, 0, 0, 0, 31'h7fffffff);
		it = '{KIND_NONE, 4'hf, 32'sh7fffffff, 0, 0, 0, 0};
		send_item(it);
		// saturating raw coefficients
		for (int i = 0; i < 16; i++)
			send_load(i, (i % 4 == 3) ? 32'sh7fffffff : ((i % 4 == 0) ? 32'sh80000000 : 32'sh10000));
		send_test(KIND_POINT, 0, 0, 0, 0);
		send_test(KIND_POINT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
		send_test(KIND_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		send_test(KIND_SPHERE, 32'sh80000000, 0, 32'sh7fffffff, 31'h7fffffff);
		send_test(KIND_SPHERE, 32'sh7fffffff, 32'sh80000000, 0, 31'h10000);

		while (sent < 1500) begin
			int r;
			if ($urandom_range(99) == 0) no_idle = !no_idle;
			r = $urandom_range(199);
			if (r < 5) load_matrix();
			else if (r < 8) send_load($urandom_range(15), mat_value($urandom_range(2)));
			else if (r < 10) begin
				it = '{KIND_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
					31'($urandom)};
				send_item(it);
			end else
				send_test($urandom_range(1) ? KIND_SPHERE : KIND_POINT,
					pos_value(), pos_value(), pos_value(), rad_value());
		end
		in_ch.valid <= 1'b0;

		while (sb.inside_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
